// ===== rtl/echt_pkg.sv =====
// types and codes for the edge count hash table
// no dependencies
package echt_pkg;
    localparam logic [1:0] CMD_RECORD = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [2:0] ST_COUNTED    = 3'd0;
    localparam logic [2:0] ST_INSERTED   = 3'd1;
    localparam logic [2:0] ST_FULL       = 3'd2;
    localparam logic [2:0] ST_READ_OK    = 3'd3;
    localparam logic [2:0] ST_READ_EMPTY = 3'd4;
    localparam logic [2:0] ST_CLEARED    = 3'd5;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_HEAD  = 7'b0000010,
        S_ENTRY = 7'b0000100,
        S_CMP   = 7'b0001000,
        S_READ  = 7'b0010000,
        S_CLR   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;
endpackage

// ===== rtl/edge_count_hash_table.sv =====
// edge count hash table top level: command fsm, bucket and pool memories
// depends on echt_pkg
//
// usage: one command item on s_axis (record edge, read pool slot, clear table),
// exactly one result item on m_axis for each, in order.
// steps from acceptance to m_axis_tvalid:
//   record: the bucket head read, then a read and compare of each chain
//   entry until a match or the chain end, then the result is presented
//   read: the pool slot read; unused command: the result is presented
//   clear: a sweep of the head memory, one bucket per cycle
// one item is in flight at a time; the result waits in an output register
// and the next item is accepted the cycle after the result is taken.
// after reset a clearing pass sweeps the bucket heads; s_axis_tready stays
// low meanwhile. pool entries are never cleared, only the fill count.
// a stalled receiver simply holds the result and blocks the input.
module edge_count_hash_table
    import echt_pkg::*;
#(
    parameter int BUCKETS = 1024,
    parameter int ENTRIES = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cmd[1:0], caller_addr[65:2], callee_addr[129:66], slot[139:130], zero fill
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], hit_count[34:3], edge_caller[98:35], edge_callee[162:99], zero fill
    output logic [167:0] m_axis_tdata
);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int UW = $clog2(ENTRIES + 1);

    // heads: valid bit + index, memory swept for clear
    logic [EW:0]  head_mem [BUCKETS];
    logic [63:0]  caller_mem [ENTRIES];
    logic [63:0]  callee_mem [ENTRIES];
    logic [31:0]  count_mem [ENTRIES];
    logic [EW:0]  link_mem [ENTRIES];

    state_t       state_reg, state_next;
    logic [1:0]   cmd_reg;
    logic [63:0]  from_reg, to_reg;
    logic [9:0]   slot_reg;
    logic [BW-1:0] bkt_reg;
    logic [EW-1:0] cur_reg;
    logic [UW-1:0] used_reg;
    logic [BW-1:0] clr_reg;
    logic         head_wait_reg;
    logic         link_pend_reg;
    logic         rst_clear_reg;

    logic [EW:0]  head_q;
    logic [63:0]  caller_q, callee_q;
    logic [31:0]  count_q;
    logic [EW:0]  link_q;

    logic         out_valid_reg;
    logic [2:0]   st_reg;
    logic [31:0]  cnt_reg;
    logic [63:0]  oc_reg, oe_reg;

    logic [EW-1:0] rd_addr;
    logic [BW-1:0] bx;
    logic         slot_ok;
    logic         take_in;
    logic         ins_head, ins_link, ins_new, bump;
    logic         full_now;
    logic         match;
    logic         chain_end;

    assign bx = s_axis_tdata[2 +: BW] ^ s_axis_tdata[66 +: BW];
    assign s_axis_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign take_in = s_axis_tvalid && s_axis_tready;
    assign slot_ok = ({{(32-10){1'b0}}, slot_reg} < 32'(used_reg))
                     && ({{(32-10){1'b0}}, slot_reg} < 32'(ENTRIES));
    assign full_now = (used_reg >= UW'(ENTRIES));
    assign match = (caller_q == from_reg) && (callee_q == to_reg);

    always_comb begin
        rd_addr = cur_reg;
        if (state_reg == S_READ) rd_addr = EW'(slot_reg);
    end

    // head memory: read every cycle at the item's bucket, written on clear sweep or on an insert into an empty bucket
    always_ff @(posedge aclk) begin
        head_q <= head_mem[bkt_reg];
        if (state_reg == S_CLR) head_mem[clr_reg] <= '0;
        else if (ins_head) head_mem[bkt_reg] <= {1'b1, EW'(used_reg)};
    end

    // pool memories; the old tail's link is written in S_OUT, at the edge that presents the result
    always_ff @(posedge aclk) begin
        caller_q <= caller_mem[rd_addr];
        callee_q <= callee_mem[rd_addr];
        count_q  <= count_mem[rd_addr];
        link_q   <= link_mem[rd_addr];
        if (ins_new) begin
            caller_mem[EW'(used_reg)] <= from_reg;
            callee_mem[EW'(used_reg)] <= to_reg;
            count_mem[EW'(used_reg)]  <= 32'd1;
            link_mem[EW'(used_reg)]   <= '0;
        end else if (bump) begin
            count_mem[cur_reg] <= count_q + 32'd1;
        end else if (state_reg == S_OUT && link_pend_reg) begin
            link_mem[cur_reg] <= {1'b1, EW'(used_reg - UW'(1))};
        end
    end

    // chain end: empty bucket, or no valid next after a miss
    always_comb begin
        chain_end = 1'b0;
        if (state_reg == S_HEAD && head_wait_reg) chain_end = !head_q[EW];
        if (state_reg == S_CMP) chain_end = !match && !link_q[EW];
    end

    always_comb begin
        ins_new  = chain_end && !full_now;
        ins_head = ins_new && (state_reg == S_HEAD);
        ins_link = ins_new && (state_reg == S_CMP);
        bump     = (state_reg == S_CMP) && match && (count_q != COUNT_MAX);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (take_in) begin
                case (s_axis_tdata[1:0])
                    CMD_RECORD: state_next = S_HEAD;
                    CMD_READ:   state_next = S_READ;
                    CMD_CLEAR:  state_next = S_CLR;
                    default:    state_next = S_OUT;
                endcase
            end
            S_HEAD:  state_next = chain_end ? S_OUT : S_ENTRY;
            S_ENTRY: state_next = S_CMP;
            S_CMP:   state_next = (match || chain_end) ? S_OUT : S_ENTRY;
            S_READ:  state_next = S_OUT;
            S_CLR:   if (clr_reg == BW'(BUCKETS - 1)) state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // S_HEAD first waits for the bucket head read, marked by head_wait_reg, before the head is used
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLR;
            used_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            head_wait_reg <= 1'b0;
            link_pend_reg <= 1'b0;
            cmd_reg       <= CMD_CLEAR;
        end else begin
            if (state_reg == S_HEAD && !head_wait_reg) begin
                head_wait_reg <= 1'b1;
            end else begin
                head_wait_reg <= 1'b0;
                state_reg <= state_next;
            end
            if (take_in) begin
                cmd_reg  <= s_axis_tdata[1:0];
                from_reg <= s_axis_tdata[65:2];
                to_reg   <= s_axis_tdata[129:66];
                slot_reg <= s_axis_tdata[139:130];
                bkt_reg  <= bx & BW'(BUCKETS - 1);
                clr_reg  <= '0;
            end else if (state_reg == S_CLR) begin
                clr_reg <= clr_reg + BW'(1);
            end
            if (state_reg == S_CLR) used_reg <= '0;
            else if (ins_new) used_reg <= used_reg + UW'(1);
            if (state_reg == S_HEAD && head_wait_reg) cur_reg <= head_q[EW-1:0];
            else if (state_reg == S_CMP && !match && link_q[EW]) cur_reg <= link_q[EW-1:0];
            if (ins_link) link_pend_reg <= 1'b1;
            else if (state_reg == S_OUT) link_pend_reg <= 1'b0;
            if (state_reg == S_OUT) out_valid_reg <= !rst_clear_reg;
            else if (out_valid_reg && m_axis_tready) out_valid_reg <= 1'b0;
        end
    end

    // the clearing pass after reset delivers no item
    always_ff @(posedge aclk) begin
        if (!aresetn) rst_clear_reg <= 1'b1;
        else if (state_reg == S_OUT) rst_clear_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (take_in) begin
            st_reg  <= ST_READ_EMPTY;
            cnt_reg <= '0;
            oc_reg  <= '0;
            oe_reg  <= '0;
        end else if (chain_end) begin
            st_reg  <= full_now ? ST_FULL : ST_INSERTED;
            cnt_reg <= full_now ? 32'd0 : 32'd1;
        end else if (state_reg == S_CMP && match) begin
            st_reg  <= ST_COUNTED;
            cnt_reg <= (count_q == COUNT_MAX) ? count_q : count_q + 32'd1;
        end else if (state_reg == S_OUT && cmd_reg == CMD_READ && slot_ok) begin
            st_reg  <= ST_READ_OK;
            cnt_reg <= count_q;
            oc_reg  <= caller_q;
            oe_reg  <= callee_q;
        end else if (state_reg == S_CLR) begin
            st_reg <= ST_CLEARED;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, oe_reg, oc_reg, cnt_reg, st_reg};

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= UW'(ENTRIES))
        else $error("pool overrun");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
endmodule
